[rtl/assert_macros.svh]
// assertion macros used by the multicore control unit
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define ASSERT_IMPLY(lbl, clk, rst_n, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
		else $error("same-cycle implication failed");

// next-cycle implication, disabled while reset is asserted
`define ASSERT_NEXT(lbl, clk, rst_n, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error("next-cycle implication failed");

`endif

[rtl/mcu_pkg.sv]
// package: constants, operation and status codes of the multicore control unit
`default_nettype none
package mcu_pkg;

	localparam int CORE_COUNT_DEF   = 8;
	localparam int SCRATCH_REGS_DEF = 24;
	localparam int IMAGE_WORDS_DEF  = 524288;

	localparam int OP_W     = 4;
	localparam int IDX_W    = 8;
	localparam int IP_W     = 20;
	localparam int RP_W     = 8;
	localparam int DATA_W   = 32;
	localparam int STAT_W   = 3;
	localparam int CORE_W   = 3;
	localparam int MASK_W   = 8;
	localparam int IN_W     = OP_W + IDX_W + IP_W + IDX_W + DATA_W;
	localparam int OUT_USED = DATA_W + STAT_W + CORE_W + MASK_W + IP_W + RP_W;
	localparam int OUT_W    = ((OUT_USED + 7) / 8) * 8;
	localparam int OUT_PAD  = OUT_W - OUT_USED;

	typedef enum logic [OP_W-1:0] {
		OP_INIT      = 4'd0,
		OP_START     = 4'd1,
		OP_PAUSE     = 4'd2,
		OP_PAUSE_CUR = 4'd3,
		OP_RESUME    = 4'd4,
		OP_READ      = 4'd5,
		OP_WRITE     = 4'd6,
		OP_SWITCH    = 4'd7
	} op_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK           = 3'd0,
		ST_BAD_CORE     = 3'd1,
		ST_BAD_REG      = 3'd2,
		ST_BAD_ACTION   = 3'd3,
		ST_NONE_RUNNING = 3'd4
	} status_t;

endpackage
`default_nettype wire

[rtl/mcu_ram.sv]
// generic single-port-write ram with registered read
`default_nettype none
module mcu_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 192,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

[rtl/multicore_control_unit.sv]
// top level: control unit for a set of emulated cores
//
// one command beat in on s_axis, one result beat out on m_axis for every command.
// a command beat carries an operation (init, start, pause, pause current, resume,
// read or write a scratch register of the current core, switch round-robin to the
// next running core); codes 8 to 15 are rejected as bad actions.
// a bad core index, bad register index or bad action halts the current core
// (ip set to the image size, rp to zero) and returns an error status.
// the command is registered at acceptance; once the result register is free or its beat
// is taken, the command is processed against the core state and the scratch ram and
// its result loads into the result register, which drives the result beat.
// throughput: one beat per cycle while the receiver takes every result, set by the
// single pass through the control logic and one scratch ram access per command.
// reset: all cores paused, ip and rp zero, current core 0, every scratch register
// reads as zero until written (per-entry valid flags, cleared at once).
// when the receiver stalls, the result register holds and the command stage fills;
// s_axis_tready drops once both are occupied, no beat is lost.
`default_nettype none
module multicore_control_unit
	import mcu_pkg::*;
#(
	parameter int CORE_COUNT   = CORE_COUNT_DEF,
	parameter int SCRATCH_REGS = SCRATCH_REGS_DEF,
	parameter int IMAGE_WORDS  = IMAGE_WORDS_DEF
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             s_axis_tvalid,
	output logic                  s_axis_tready,
	// operation[3:0], core_index[11:4], start_address[31:12],
	// register_index[39:32], write_value[71:40]
	input  wire logic [IN_W-1:0]  s_axis_tdata,
	output logic                  m_axis_tvalid,
	input  wire logic             m_axis_tready,
	// read_data[31:0], status[34:32], current_core[37:35], running_mask[45:38],
	// current_ip[65:46], current_rp[73:66], zero fill[79:74]
	output logic      [OUT_W-1:0] m_axis_tdata
);

	`include "assert_macros.svh"

	localparam int CIDX_W = (CORE_COUNT > 1) ? $clog2(CORE_COUNT) : 1;
	localparam int REG_W  = (SCRATCH_REGS > 1) ? $clog2(SCRATCH_REGS) : 1;
	localparam int DEPTH  = CORE_COUNT * SCRATCH_REGS;
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int SUM_W  = CIDX_W + 2;

	// ip of a halted core
	localparam logic [IP_W-1:0] HALT_IP = IP_W'(IMAGE_WORDS);

	// command stage
	logic              valid_s1;
	logic [OP_W-1:0]   op_s1;
	logic [IDX_W-1:0]  core_s1;
	logic [IP_W-1:0]   addr_s1;
	logic [IDX_W-1:0]  reg_s1;
	logic [DATA_W-1:0] wval_s1;

	// core state
	logic [CIDX_W-1:0]     active_q;
	logic [CORE_COUNT-1:0] run_q;
	logic [IP_W-1:0]       ip_q [CORE_COUNT];
	logic [RP_W-1:0]       rp_q [CORE_COUNT];
	logic [DEPTH-1:0]      ent_valid_q;

	// result stage
	logic              valid_s2;
	status_t           status_s2;
	logic [CORE_W-1:0] core_s2;
	logic [MASK_W-1:0] mask_s2;
	logic [IP_W-1:0]   ip_s2;
	logic [RP_W-1:0]   rp_s2;
	logic              rd_ok_s2;
	logic              err_s2;

	// next-state logic
	logic                  adv_s1;
	logic                  core_ok;
	logic                  reg_ok;
	logic [CIDX_W-1:0]     core_sel;
	logic [CIDX_W-1:0]     active_d;
	logic [CORE_COUNT-1:0] run_d;
	logic [IP_W-1:0]       ip_d [CORE_COUNT];
	logic [RP_W-1:0]       rp_d [CORE_COUNT];
	status_t               status_d;
	logic                  clr_row;
	logic                  ram_we;
	logic                  ram_re;
	logic                  found;
	logic [SUM_W-1:0]      cand;
	logic [ADDR_W-1:0]     ram_addr;
	logic [DATA_W-1:0]     ram_rdata;
	logic [DATA_W-1:0]     rd_data;

	// handshake: the command stage moves on whenever the result register is free or its beat is taken
	assign adv_s1        = valid_s1 && (!valid_s2 || m_axis_tready);
	assign s_axis_tready = !valid_s1 || adv_s1;
	assign m_axis_tvalid = valid_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	// command payload, no reset needed
	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			op_s1   <= s_axis_tdata[OP_W-1:0];
			core_s1 <= s_axis_tdata[OP_W +: IDX_W];
			addr_s1 <= s_axis_tdata[OP_W+IDX_W +: IP_W];
			reg_s1  <= s_axis_tdata[OP_W+IDX_W+IP_W +: IDX_W];
			wval_s1 <= s_axis_tdata[OP_W+2*IDX_W+IP_W +: DATA_W];
		end
	end

	assign core_ok  = core_s1 < IDX_W'(CORE_COUNT);
	assign reg_ok   = reg_s1 < IDX_W'(SCRATCH_REGS);
	assign core_sel = core_s1[CIDX_W-1:0];
	// scratch entry of the current core
	assign ram_addr = ADDR_W'(active_q) * ADDR_W'(SCRATCH_REGS)
		+ ADDR_W'(reg_s1[REG_W-1:0]);

	always_comb begin
		active_d = active_q;
		run_d    = run_q;
		ip_d     = ip_q;
		rp_d     = rp_q;
		status_d = ST_OK;
		clr_row  = 1'b0;
		ram_we   = 1'b0;
		ram_re   = 1'b0;
		found    = 1'b0;
		cand     = '0;
		case (op_t'(op_s1))
			OP_INIT: begin
				if (core_ok) begin
					ip_d[core_sel]  = '0;
					rp_d[core_sel]  = '0;
					run_d[core_sel] = 1'b0;
					clr_row         = 1'b1;
				end else begin
					status_d = ST_BAD_CORE;
				end
			end
			OP_START: begin
				if (core_ok) begin
					ip_d[core_sel]  = addr_s1;
					rp_d[core_sel]  = RP_W'(1);
					run_d[core_sel] = 1'b1;
				end else begin
					status_d = ST_BAD_CORE;
				end
			end
			OP_PAUSE, OP_RESUME: begin
				if (core_ok) begin
					run_d[core_sel] = (op_t'(op_s1) == OP_RESUME);
				end else begin
					status_d = ST_BAD_CORE;
				end
			end
			OP_PAUSE_CUR: begin
				run_d[active_q] = 1'b0;
			end
			OP_READ: begin
				if (reg_ok) begin
					ram_re = 1'b1;
				end else begin
					status_d = ST_BAD_REG;
				end
			end
			OP_WRITE: begin
				if (reg_ok) begin
					ram_we = 1'b1;
				end else begin
					status_d = ST_BAD_REG;
				end
			end
			OP_SWITCH: begin
				// ring search from the core after the current one, current one last
				for (int k = 1; k <= CORE_COUNT; k++) begin
					cand = SUM_W'(active_q) + SUM_W'(k);
					if (cand >= SUM_W'(CORE_COUNT)) begin
						cand = cand - SUM_W'(CORE_COUNT);
					end
					if (!found && run_q[cand[CIDX_W-1:0]]) begin
						active_d = cand[CIDX_W-1:0];
						found    = 1'b1;
					end
				end
				status_d = found ? ST_OK : ST_NONE_RUNNING;
			end
			default: begin
				status_d = ST_BAD_ACTION;
			end
		endcase
		// errors halt the current core
		if (status_d inside {ST_BAD_CORE, ST_BAD_REG, ST_BAD_ACTION}) begin
			ip_d[active_q] = HALT_IP;
			rp_d[active_q] = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= '0;
			run_q    <= '0;
			for (int i = 0; i < CORE_COUNT; i++) begin
				ip_q[i] <= '0;
				rp_q[i] <= '0;
			end
		end else if (adv_s1) begin
			active_q <= active_d;
			run_q    <= run_d;
			ip_q     <= ip_d;
			rp_q     <= rp_d;
		end
	end

	// per-entry valid flags: an entry never written since reset or init reads zero
	for (genvar e = 0; e < DEPTH; e++) begin : g_ent
		localparam int ROW = e / SCRATCH_REGS;
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				ent_valid_q[e] <= 1'b0;
			end else if (adv_s1 && clr_row && core_sel == CIDX_W'(ROW)) begin
				ent_valid_q[e] <= 1'b0;
			end else if (adv_s1 && ram_we && ram_addr == ADDR_W'(e)) begin
				ent_valid_q[e] <= 1'b1;
			end
		end
	end

	mcu_ram #(
		.WIDTH (DATA_W),
		.DEPTH (DEPTH)
	) u_scratch (
		.clk   (clk),
		.we    (adv_s1 && ram_we),
		.waddr (ram_addr),
		.wdata (wval_s1),
		.re    (adv_s1 && ram_re),
		.raddr (ram_addr),
		.rdata (ram_rdata)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s1) begin
			valid_s2 <= 1'b1;
		end else if (m_axis_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			status_s2 <= status_d;
			core_s2   <= CORE_W'(active_d);
			mask_s2   <= MASK_W'(run_d);
			ip_s2     <= ip_d[active_d];
			rp_s2     <= rp_d[active_d];
			rd_ok_s2  <= ram_re && ent_valid_q[ram_addr];
		end
	end

	// ram output is held while stalled since no read is issued then
	assign rd_data = rd_ok_s2 ? ram_rdata : '0;

	// error status in the result register
	assign err_s2 = status_s2 inside {ST_BAD_CORE, ST_BAD_REG, ST_BAD_ACTION};

	assign m_axis_tdata = {{OUT_PAD{1'b0}}, rp_s2, ip_s2, mask_s2, core_s2, status_s2, rd_data};

	`ASSERT_IMPLY(a_stall_blocks, clk, arst_n, valid_s2 && !m_axis_tready, !adv_s1)
	`ASSERT_NEXT(a_adv_fills, clk, arst_n, adv_s1, valid_s2)
	`ASSERT_IMPLY(a_error_halts, clk, arst_n, valid_s2 && err_s2, rp_s2 == '0 && ip_s2 == HALT_IP)
	`ASSERT_IMPLY(a_none_running, clk, arst_n, valid_s2 && status_s2 == ST_NONE_RUNNING, mask_s2 == '0)
	`ASSERT_IMPLY(a_read_only_ok, clk, arst_n, valid_s2 && rd_data != '0, status_s2 == ST_OK)

endmodule
`default_nettype wire

[verif/testbench.sv]
// testbench for the multicore control unit: directed command table, then random commands
`timescale 1ns / 1ps
module testbench
	import mcu_pkg::*;
();

	localparam int CLK_HALF_NS  = 4;
	localparam int RESET_CYCLES = 11;
	localparam int DIR_ROWS     = 25;
	localparam int RANDOM_ITEMS = 1850;
	localparam int DRAIN_CYCLES = 16;
	localparam int IDLE_PCT     = 17;
	localparam int TIMEOUT_NS   = 5_000_000;

	// codes outside the defined operations are rejected by the block
	localparam logic [OP_W-1:0] OP_BAD_FIRST = 4'd8;
	localparam logic [OP_W-1:0] OP_BAD_LAST  = 4'd15;

	localparam logic [IP_W-1:0] HALT_IP = IMAGE_WORDS_DEF[IP_W-1:0];

	// command beat, lowest field last
	typedef struct packed {
		logic [DATA_W-1:0] wr_value;
		logic [IDX_W-1:0]  reg_idx;
		logic [IP_W-1:0]   start_addr;
		logic [IDX_W-1:0]  core_idx;
		logic [OP_W-1:0]   opcode;
	} ctl_cmd_t;

	// result beat, lowest field last
	typedef struct packed {
		logic [OUT_PAD-1:0] fill;
		logic [RP_W-1:0]    cur_rp;
		logic [IP_W-1:0]    cur_ip;
		logic [MASK_W-1:0]  run_mask;
		logic [CORE_W-1:0]  cur_core;
		status_t            status;
		logic [DATA_W-1:0]  rd_data;
	} ctl_result_t;

	typedef struct {
		logic [OP_W-1:0]   opcode;
		logic [IDX_W-1:0]  core_idx;
		logic [IP_W-1:0]   start_addr;
		logic [IDX_W-1:0]  reg_idx;
		logic [DATA_W-1:0] wr_value;
		bit                typed;
		status_t           exp_status;
		logic [DATA_W-1:0] exp_rdata;
	} dir_row_t;

	logic             clk;
	logic             arst_n = 1'b0;
	logic             s_axis_tvalid = 1'b0;
	logic             s_axis_tready;
	logic [IN_W-1:0]  s_axis_tdata = '0;
	logic             m_axis_tvalid;
	logic             m_axis_tready = 1'b0;
	logic [OUT_W-1:0] m_axis_tdata;

	// no idling on either side while this is set
	bit steady_phase = 1'b0;

	// predicted core state
	logic [CORE_W-1:0] model_cur;
	logic              model_on [CORE_COUNT_DEF];
	logic [IP_W-1:0]   model_ip [CORE_COUNT_DEF];
	logic [RP_W-1:0]   model_rp [CORE_COUNT_DEF];
	logic [DATA_W-1:0] model_scratch [CORE_COUNT_DEF][SCRATCH_REGS_DEF];

	ctl_result_t pending_results [$];

	int mismatch_count = 0;
	int n_sent = 0;
	int n_checked = 0;
	int n_switch = 0;
	int n_reg_access = 0;
	int n_err_status = 0;

	// typed expectations only where the outcome is obvious
	dir_row_t directed_rows [DIR_ROWS] = '{
		'{OP_READ,      8'd0,   20'd0,       8'd0,   32'd0,         1'b1, ST_OK,           32'd0},
		'{OP_SWITCH,    8'd0,   20'd0,       8'd0,   32'd0,         1'b1, ST_NONE_RUNNING, 32'd0},
		'{OP_WRITE,     8'd0,   20'd0,       8'd23,  32'h7fffffff,  1'b0, ST_OK,           32'd0},
		'{OP_READ,      8'd0,   20'd0,       8'd23,  32'd0,         1'b1, ST_OK,  32'h7fffffff},
		'{OP_WRITE,     8'd0,   20'd0,       8'd0,   32'h80000000,  1'b0, ST_OK,           32'd0},
		'{OP_READ,      8'd0,   20'd0,       8'd0,   32'd0,         1'b1, ST_OK,  32'h80000000},
		'{OP_READ,      8'd0,   20'd0,       8'd24,  32'd0,         1'b1, ST_BAD_REG,      32'd0},
		'{OP_WRITE,     8'd0,   20'd0,       8'hff,  32'hffffffff,  1'b1, ST_BAD_REG,      32'd0},
		'{OP_START,     8'd0,   20'hfffff,   8'd0,   32'd0,         1'b0, ST_OK,           32'd0},
		'{OP_START,     8'd7,   20'd0,       8'd0,   32'd0,         1'b0, ST_OK,           32'd0},
		'{OP_START,     8'd8,   20'h12345,   8'd0,   32'd0,         1'b1, ST_BAD_CORE,     32'd0},
		'{OP_START,     8'hff,  20'hfffff,   8'hff,  32'hffffffff,  1'b1, ST_BAD_CORE,     32'd0},
		'{OP_INIT,      8'hff,  20'd0,       8'd0,   32'd0,         1'b1, ST_BAD_CORE,     32'd0},
		'{OP_PAUSE,     8'd7,   20'd0,       8'd0,   32'd0,         1'b0, ST_OK,           32'd0},
		'{OP_RESUME,    8'd7,   20'd0,       8'd0,   32'd0,         1'b0, ST_OK,           32'd0},
		'{OP_SWITCH,    8'd0,   20'd0,       8'd0,   32'd0,         1'b0, ST_OK,           32'd0},
		'{OP_WRITE,     8'd0,   20'd0,       8'd5,   32'h5a5a5a5a,  1'b0, ST_OK,           32'd0},
		'{OP_PAUSE_CUR, 8'd0,   20'd0,       8'd0,   32'd0,         1'b0, ST_OK,           32'd0},
		'{OP_SWITCH,    8'd0,   20'd0,       8'd0,   32'd0,         1'b0, ST_OK,           32'd0},
		'{OP_BAD_FIRST, 8'd0,   20'd0,       8'd0,   32'd0,         1'b1, ST_BAD_ACTION,   32'd0},
		'{OP_BAD_LAST,  8'hff,  20'hfffff,   8'hff,  32'hffffffff,  1'b1, ST_BAD_ACTION,   32'd0},
		'{OP_PAUSE,     8'd200, 20'd0,       8'd0,   32'd0,         1'b1, ST_BAD_CORE,     32'd0},
		'{OP_RESUME,    8'd8,   20'd0,       8'd0,   32'd0,         1'b1, ST_BAD_CORE,     32'd0},
		'{OP_INIT,      8'd7,   20'd0,       8'd0,   32'd0,         1'b0, ST_OK,           32'd0},
		'{OP_SWITCH,    8'd0,   20'd0,       8'd0,   32'd0,         1'b0, ST_OK,           32'd0}
	};

	multicore_control_unit u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #(CLK_HALF_NS) clk = ~clk;
	end

	// state after reset: everything zero, all cores paused
	initial begin
		model_cur = '0;
		for (int c = 0; c < CORE_COUNT_DEF; c++) begin
			model_on[c] = 1'b0;
			model_ip[c] = '0;
			model_rp[c] = '0;
			for (int r = 0; r < SCRATCH_REGS_DEF; r++)
				model_scratch[c][r] = '0;
		end
	end

	// applies one command to the predicted core state, returns the result beat
	function automatic ctl_result_t apply_command(ctl_cmd_t c);
		ctl_result_t       r;
		logic              core_ok;
		logic              reg_ok;
		logic [CORE_W-1:0] tgt;
		logic [CORE_W-1:0] cand;
		r = '0;
		r.status = ST_OK;
		core_ok = c.core_idx < CORE_COUNT_DEF;
		reg_ok = c.reg_idx < SCRATCH_REGS_DEF;
		tgt = c.core_idx[CORE_W-1:0];
		case (c.opcode)
			OP_INIT: begin
				if (core_ok) begin
					model_ip[tgt] = '0;
					model_rp[tgt] = '0;
					model_on[tgt] = 1'b0;
					for (int i = 0; i < SCRATCH_REGS_DEF; i++)
						model_scratch[tgt][i] = '0;
				end else
					r.status = ST_BAD_CORE;
			end
			OP_START: begin
				if (core_ok) begin
					model_ip[tgt] = c.start_addr;
					model_rp[tgt] = 8'd1;
					model_on[tgt] = 1'b1;
				end else
					r.status = ST_BAD_CORE;
			end
			OP_PAUSE, OP_RESUME: begin
				if (core_ok)
					model_on[tgt] = (c.opcode == OP_RESUME);
				else
					r.status = ST_BAD_CORE;
			end
			OP_PAUSE_CUR: model_on[model_cur] = 1'b0;
			OP_READ: begin
				if (reg_ok)
					r.rd_data = model_scratch[model_cur][c.reg_idx];
				else
					r.status = ST_BAD_REG;
			end
			OP_WRITE: begin
				if (reg_ok)
					model_scratch[model_cur][c.reg_idx] = c.wr_value;
				else
					r.status = ST_BAD_REG;
			end
			OP_SWITCH: begin
				// ring order after the current core, the current core itself last
				r.status = ST_NONE_RUNNING;
				for (int k = 1; k <= CORE_COUNT_DEF; k++) begin
					cand = CORE_W'((int'(model_cur) + k) % CORE_COUNT_DEF);
					if (r.status == ST_NONE_RUNNING && model_on[cand]) begin
						model_cur = cand;
						r.status = ST_OK;
					end
				end
			end
			default: r.status = ST_BAD_ACTION;
		endcase
		// any error except an empty switch halts the current core
		if (r.status inside {ST_BAD_CORE, ST_BAD_REG, ST_BAD_ACTION}) begin
			model_ip[model_cur] = HALT_IP;
			model_rp[model_cur] = '0;
		end
		for (int i = 0; i < CORE_COUNT_DEF; i++)
			r.run_mask[i] = model_on[i];
		r.cur_core = model_cur;
		r.cur_ip = model_ip[model_cur];
		r.cur_rp = model_rp[model_cur];
		return r;
	endfunction

	// mostly valid targets so that cores keep running and switches have work to do
	function automatic ctl_cmd_t make_random_cmd();
		ctl_cmd_t c;
		int       pick;
		pick = $urandom_range(0, 99);
		c.core_idx = ($urandom_range(0, 19) == 0) ? IDX_W'($urandom_range(8, 255))
			: IDX_W'($urandom_range(0, CORE_COUNT_DEF - 1));
		c.reg_idx = ($urandom_range(0, 19) == 0) ? IDX_W'($urandom_range(24, 255))
			: IDX_W'($urandom_range(0, SCRATCH_REGS_DEF - 1));
		c.start_addr = IP_W'($urandom);
		c.wr_value = $urandom;
		if (pick < 4)
			c.opcode = OP_INIT;
		else if (pick < 16)
			c.opcode = OP_START;
		else if (pick < 24)
			c.opcode = OP_PAUSE;
		else if (pick < 29)
			c.opcode = OP_PAUSE_CUR;
		else if (pick < 39)
			c.opcode = OP_RESUME;
		else if (pick < 59)
			c.opcode = OP_READ;
		else if (pick < 79)
			c.opcode = OP_WRITE;
		else if (pick < 95)
			c.opcode = OP_SWITCH;
		else
			c.opcode = OP_W'($urandom_range(OP_BAD_FIRST, OP_BAD_LAST));
		return c;
	endfunction

	// drives one command beat, queues its expected result once accepted
	task automatic send_command(input ctl_cmd_t c, input bit typed, input status_t t_status,
			input logic [DATA_W-1:0] t_rdata);
		ctl_result_t exp_res;
		while (!steady_phase && $urandom_range(0, 99) < IDLE_PCT) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= c;
		do @(posedge clk); while (!s_axis_tready);
		exp_res = apply_command(c);
		if (typed) begin
			exp_res.status = t_status;
			exp_res.rd_data = t_rdata;
		end
		pending_results.push_back(exp_res);
		n_sent++;
		if (c.opcode == OP_SWITCH)
			n_switch++;
		if (c.opcode == OP_READ || c.opcode == OP_WRITE)
			n_reg_access++;
		if (exp_res.status inside {ST_BAD_CORE, ST_BAD_REG, ST_BAD_ACTION, ST_NONE_RUNNING})
			n_err_status++;
	endtask

	function automatic void report_field(string field, logic [DATA_W-1:0] expv,
			logic [DATA_W-1:0] gotv);
		if (expv !== gotv) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, expv, gotv);
			mismatch_count++;
		end
	endfunction

	// result side: random back-pressure, every beat compared with the oldest expectation
	always @(posedge clk) begin
		ctl_result_t got;
		ctl_result_t want;
		if (!arst_n)
			m_axis_tready <= 1'b0;
		else
			m_axis_tready <= steady_phase || ($urandom_range(0, 99) >= IDLE_PCT);
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = ctl_result_t'(m_axis_tdata);
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result beat, expected none, actual %0h",
					$time, m_axis_tdata);
				mismatch_count++;
			end else begin
				want = pending_results.pop_front();
				n_checked++;
				report_field("read_data", want.rd_data, got.rd_data);
				report_field("status", DATA_W'(want.status), DATA_W'(got.status));
				report_field("current_core", DATA_W'(want.cur_core), DATA_W'(got.cur_core));
				report_field("running_mask", DATA_W'(want.run_mask), DATA_W'(got.run_mask));
				report_field("current_ip", DATA_W'(want.cur_ip), DATA_W'(got.cur_ip));
				report_field("current_rp", DATA_W'(want.cur_rp), DATA_W'(got.cur_rp));
				report_field("zero fill", DATA_W'(want.fill), DATA_W'(got.fill));
			end
		end
	end

	initial begin
		ctl_cmd_t cmd;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (int i = 0; i < DIR_ROWS; i++) begin
			cmd.opcode = directed_rows[i].opcode;
			cmd.core_idx = directed_rows[i].core_idx;
			cmd.start_addr = directed_rows[i].start_addr;
			cmd.reg_idx = directed_rows[i].reg_idx;
			cmd.wr_value = directed_rows[i].wr_value;
			send_command(cmd, directed_rows[i].typed, directed_rows[i].exp_status,
				directed_rows[i].exp_rdata);
		end
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			// a long stretch in the middle runs without gaps or stalls
			steady_phase <= (i >= 700 && i < 1000);
			send_command(make_random_cmd(), 1'b0, ST_OK, '0);
		end
		s_axis_tvalid <= 1'b0;
		steady_phase <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("%0d commands sent (%0d from the table): %0d switches, %0d register accesses",
			n_sent, DIR_ROWS, n_switch, n_reg_access);
		$display("%0d result beats compared, %0d with an error status, %0d mismatches",
			n_checked, n_err_status, mismatch_count);
		if (mismatch_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	initial begin
		#(TIMEOUT_NS);
		$display("%0t: timeout with %0d results outstanding", $time, pending_results.size());
		$display("simulation failed");
		$finish;
	end

endmodule

[files.f]
+incdir+rtl
rtl/mcu_pkg.sv
rtl/mcu_ram.sv
rtl/multicore_control_unit.sv
verif/testbench.sv
